### hdl/fsfla_pkg.sv
// Shared constants, register codes and control types for the slot allocator.
package fsfla_pkg;

  // Pool geometry
  localparam int SLOTS          = 256;
  localparam int SLOT_ALIGN     = 16;
  localparam int MIN_SLOT_BYTES = 8;

  // Field widths
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int LINK_W   = 9;
  localparam int CNT_W    = 9;
  localparam int BYTES_W  = 13;
  localparam int SIZE_W   = BYTES_W + 1;
  localparam int OFF_W    = 20;
  localparam int PROD_W   = IDX_W + SIZE_W;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0]   SLOT_COUNT_RST = CNT_W'(256);
  localparam logic [BYTES_W-1:0] SLOT_BYTES_RST = BYTES_W'(64);

  // Register indexes (paddr[2])
  localparam logic REG_SLOT_COUNT = 1'b0;
  localparam logic REG_SLOT_BYTES = 1'b1;

  // Request kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch request, start link read at the head
    logic commit;   // apply the request and load the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_stall;  // result register full and not taken
  } ctrl_sts_t;

  // Register block to datapath
  typedef struct packed {
    logic             rebuild;    // slot_count written this cycle
    logic [CNT_W-1:0] new_count;  // value being written
  } cfg_evt_t;

endpackage

### hdl/fsfla_req_if.sv
// Request channel: kind, slot_valid and slot_index with valid/ready.
interface fsfla_req_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic                      slot_valid;
  logic [fsfla_pkg::IDX_W-1:0] slot_index;

  modport source (output valid, kind, slot_valid, slot_index, input ready);
  modport sink   (input valid, kind, slot_valid, slot_index, output ready);
endinterface

### hdl/fsfla_rsp_if.sv
// Result channel: grant, slot index, byte offset, counts and error flag.
interface fsfla_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          granted;
  logic [fsfla_pkg::IDX_W-1:0]   given_index;
  logic [fsfla_pkg::OFF_W-1:0]   byte_offset;
  logic [fsfla_pkg::CNT_W-1:0]   free_slots;
  logic [fsfla_pkg::CNT_W-1:0]   used_slots;
  logic                          release_error;

  modport source (output valid, granted, given_index, byte_offset, free_slots,
                  used_slots, release_error, input ready);
  modport sink   (input valid, granted, given_index, byte_offset, free_slots,
                  used_slots, release_error, output ready);
endinterface

### hdl/fixed_slot_free_list_allocator.sv
// A request is captured in S_IDLE and loaded into the result register in S_EXEC;
// no new request is taken until the last is committed, due to the registered read
// of the link at the list head; a full, untaken result register stalls S_EXEC.
// Reset (synchronous): 256 slots free, slot size 64, list head at slot 0;
// link-valid bits all clear on the reset edge, so no clearing pass runs.
module fixed_slot_free_list_allocator (
  input  logic                         clk,
  input  logic                         rst,
  fsfla_req_if.sink                    req,
  fsfla_rsp_if.source                  rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsfla_pkg::APB_AW-1:0] paddr,
  input  logic [fsfla_pkg::APB_DW-1:0] pwdata,
  output logic [fsfla_pkg::APB_DW-1:0] prdata,
  output logic                         pready
);

  logic [fsfla_pkg::CNT_W-1:0]   slot_count;
  logic [fsfla_pkg::BYTES_W-1:0] slot_bytes;
  fsfla_pkg::cfg_evt_t           cfg_evt;
  fsfla_pkg::ctrl_cmd_t          cmd;
  fsfla_pkg::ctrl_sts_t          sts;

  fsfla_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .slot_count (slot_count),
    .slot_bytes (slot_bytes),
    .cfg_evt    (cfg_evt)
  );

  fsfla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fsfla_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_evt           (cfg_evt),
    .slot_count        (slot_count),
    .slot_bytes        (slot_bytes),
    .in_kind           (req.kind),
    .in_slot_valid     (req.slot_valid),
    .in_slot_index     (req.slot_index),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_granted       (rsp.granted),
    .out_given_index   (rsp.given_index),
    .out_byte_offset   (rsp.byte_offset),
    .out_free_slots    (rsp.free_slots),
    .out_used_slots    (rsp.used_slots),
    .out_release_error (rsp.release_error)
  );

endmodule

### hdl/fsfla_regs.sv
// APB register block holding slot_count and slot_bytes.
module fsfla_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fsfla_pkg::APB_AW-1:0]    paddr,
  input  logic [fsfla_pkg::APB_DW-1:0]    pwdata,
  output logic [fsfla_pkg::APB_DW-1:0]    prdata,
  output logic                            pready,
  output logic [fsfla_pkg::CNT_W-1:0]     slot_count,
  output logic [fsfla_pkg::BYTES_W-1:0]   slot_bytes,
  output fsfla_pkg::cfg_evt_t             cfg_evt
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Flag a slot_count write so the datapath rebuilds the list on the same edge
  assign cfg_evt.rebuild   = wr_en && (reg_sel == fsfla_pkg::REG_SLOT_COUNT);
  assign cfg_evt.new_count = pwdata[fsfla_pkg::CNT_W-1:0];

  // Hold register values
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= fsfla_pkg::SLOT_COUNT_RST;
      slot_bytes <= fsfla_pkg::SLOT_BYTES_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        fsfla_pkg::REG_SLOT_COUNT: slot_count <= pwdata[fsfla_pkg::CNT_W-1:0];
        fsfla_pkg::REG_SLOT_BYTES: slot_bytes <= pwdata[fsfla_pkg::BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      fsfla_pkg::REG_SLOT_COUNT: prdata = fsfla_pkg::APB_DW'(slot_count);
      fsfla_pkg::REG_SLOT_BYTES: prdata = fsfla_pkg::APB_DW'(slot_bytes);
      default:                   prdata = '0;
    endcase
  end

endmodule

### hdl/fsfla_ctrl.sv
// Controller: two-state sequencer that captures a request and commits it.
module fsfla_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  fsfla_pkg::ctrl_sts_t sts,
  output fsfla_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Accept only in idle; commit once the result register can take the result
  assign req_ready   = (state == S_IDLE);
  assign cmd.capture = (state == S_IDLE) && req_valid;
  assign cmd.commit  = (state == S_EXEC) && !sts.out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/fsfla_dp.sv
// Datapath: link store, list head, free count, offset multiply, result register.
module fsfla_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  fsfla_pkg::ctrl_cmd_t           cmd,
  output fsfla_pkg::ctrl_sts_t           sts,
  input  fsfla_pkg::cfg_evt_t            cfg_evt,
  input  logic [fsfla_pkg::CNT_W-1:0]    slot_count,
  input  logic [fsfla_pkg::BYTES_W-1:0]  slot_bytes,
  input  logic                           in_kind,
  input  logic                           in_slot_valid,
  input  logic [fsfla_pkg::IDX_W-1:0]    in_slot_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_granted,
  output logic [fsfla_pkg::IDX_W-1:0]    out_given_index,
  output logic [fsfla_pkg::OFF_W-1:0]    out_byte_offset,
  output logic [fsfla_pkg::CNT_W-1:0]    out_free_slots,
  output logic [fsfla_pkg::CNT_W-1:0]    out_used_slots,
  output logic                           out_release_error
);

  localparam int IDX_W   = fsfla_pkg::IDX_W;
  localparam int LINK_W  = fsfla_pkg::LINK_W;
  localparam int CNT_W   = fsfla_pkg::CNT_W;
  localparam int SIZE_W  = fsfla_pkg::SIZE_W;
  localparam int PROD_W  = fsfla_pkg::PROD_W;
  localparam int OFF_W   = fsfla_pkg::OFF_W;

  // List state
  logic [LINK_W-1:0] head;
  logic [CNT_W-1:0]  free_total;
  logic [LINK_W-1:0] link_mem [fsfla_pkg::SLOTS];
  logic              link_valid [fsfla_pkg::SLOTS];

  // Captured request and registered link read
  logic              kind_q;
  logic              valid_q;
  logic [IDX_W-1:0]  idx_q;
  logic [LINK_W-1:0] rd_data;
  logic              rd_hit;

  // Commit-time logic
  logic [CNT_W-1:0]  cnt_eff;
  logic [CNT_W-1:0]  rebuild_cnt;
  logic [SIZE_W-1:0] size_min;
  logic [SIZE_W-1:0] size_sum;
  logic [SIZE_W-1:0] size_aligned;
  logic [PROD_W-1:0] offset_prod;
  logic [LINK_W-1:0] head_link;
  logic              alloc_ok;
  logic              rel_err;
  logic              rel_ok;
  logic              link_we;
  logic [LINK_W-1:0] head_next;
  logic [CNT_W-1:0]  free_next;

  // Clamp slot_count into 1..SLOTS
  always_comb begin
    priority if (slot_count == '0)
      cnt_eff = CNT_W'(1);
    else if (32'(slot_count) > fsfla_pkg::SLOTS)
      cnt_eff = CNT_W'(fsfla_pkg::SLOTS);
    else
      cnt_eff = slot_count;
    priority if (cfg_evt.new_count == '0)
      rebuild_cnt = CNT_W'(1);
    else if (32'(cfg_evt.new_count) > fsfla_pkg::SLOTS)
      rebuild_cnt = CNT_W'(fsfla_pkg::SLOTS);
    else
      rebuild_cnt = cfg_evt.new_count;
  end

  // Round slot size up to the minimum, then to the alignment
  assign size_min = (32'(slot_bytes) < fsfla_pkg::MIN_SLOT_BYTES)
                  ? SIZE_W'(fsfla_pkg::MIN_SLOT_BYTES) : SIZE_W'(slot_bytes);
  assign size_sum     = size_min + SIZE_W'(fsfla_pkg::SLOT_ALIGN - 1);
  assign size_aligned = size_sum & ~SIZE_W'(fsfla_pkg::SLOT_ALIGN - 1);
  assign offset_prod  = PROD_W'(head[IDX_W-1:0]) * PROD_W'(size_aligned);

  // An entry never written since the last reset or rebuild links to the next slot
  assign head_link = rd_hit ? rd_data : head + LINK_W'(1);

  // Decide the request
  assign alloc_ok = (kind_q == fsfla_pkg::KIND_ALLOC) && (free_total != '0)
                 && (head < LINK_W'(cnt_eff)) && (32'(head) < fsfla_pkg::SLOTS);
  assign rel_err  = (kind_q == fsfla_pkg::KIND_RELEASE) && valid_q
                 && (free_total >= cnt_eff);
  assign rel_ok   = (kind_q == fsfla_pkg::KIND_RELEASE) && valid_q && !rel_err
                 && (CNT_W'(idx_q) < cnt_eff);
  assign link_we  = cmd.commit && rel_ok;

  always_comb begin
    head_next = head;
    free_next = free_total;
    if (alloc_ok) begin
      head_next = head_link;
      free_next = free_total - CNT_W'(1);
    end else if (rel_ok) begin
      head_next = LINK_W'(idx_q);
      free_next = free_total + CNT_W'(1);
    end
  end

  assign sts.out_stall = out_valid && !out_ready;

  // Capture request and read the link at the head
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q  <= in_kind;
      valid_q <= in_slot_valid;
      idx_q   <= in_slot_index;
      rd_data <= link_mem[head[IDX_W-1:0]];
      rd_hit  <= link_valid[head[IDX_W-1:0]];
    end
  end

  // Push a released slot onto the list
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[idx_q] <= head;
    end
  end

  // Drop all written links on reset or rebuild
  always_ff @(posedge clk) begin
    if (rst || cfg_evt.rebuild) begin
      for (int i = 0; i < fsfla_pkg::SLOTS; i++) link_valid[i] <= 1'b0;
    end else if (link_we) begin
      link_valid[idx_q] <= 1'b1;
    end
  end

  // Advance head and free count
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      free_total <= CNT_W'(fsfla_pkg::SLOTS);
    end else if (cfg_evt.rebuild) begin
      head       <= '0;
      free_total <= rebuild_cnt;
    end else if (cmd.commit) begin
      head       <= head_next;
      free_total <= free_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_granted       <= alloc_ok;
      out_given_index   <= alloc_ok ? head[IDX_W-1:0] : '0;
      out_byte_offset   <= alloc_ok ? offset_prod[OFF_W-1:0] : '0;
      out_free_slots    <= free_next;
      out_used_slots    <= cnt_eff - free_next;
      out_release_error <= rel_err;
    end
  end

  // Free count never exceeds the pool size
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= cnt_eff)
    else $error("free count above pool size");

  // A grant takes exactly one slot off the free count
  a_grant_dec: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && alloc_ok) |=> (free_total == $past(free_total) - CNT_W'(1)))
    else $error("grant did not decrement free count");

  // A granted slot lies inside the pool
  a_grant_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_granted) |-> (CNT_W'(out_given_index) < cnt_eff))
    else $error("granted slot outside pool");

endmodule
